>>> design/bpe_marker_cleaner_assert.svh
// Assertion macros of the marker cleaner RTL, included by its top level.
`ifndef BPE_MARKER_CLEANER_ASSERT_SVH
`define BPE_MARKER_CLEANER_ASSERT_SVH

// checked out of reset only
`define BMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset as well
`define BMC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/bmc_pkg.sv
// Types and constants of the BPE marker cleaner.
package bmc_pkg;

  typedef enum logic [1:0] {
    HOLD_NONE = 2'd0,
    HOLD_C4   = 2'd1,
    HOLD_E2   = 2'd2,
    HOLD_E296 = 2'd3
  } hold_t;

  localparam logic [7:0] BYTE_C4    = 8'hC4;
  localparam logic [7:0] BYTE_A0    = 8'hA0;
  localparam logic [7:0] BYTE_8A    = 8'h8A;
  localparam logic [7:0] BYTE_80    = 8'h80;
  localparam logic [7:0] BYTE_C0    = 8'hC0;
  localparam logic [7:0] BYTE_E2    = 8'hE2;
  localparam logic [7:0] BYTE_96    = 8'h96;
  localparam logic [7:0] BYTE_81    = 8'h81;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_LF    = 8'h0A;

  localparam int unsigned GRP_MAX = 3;

  // results caused by one input byte; entry 0 leaves first
  typedef struct packed {
    logic [1:0]              cnt;
    logic [GRP_MAX-1:0][7:0] data;
    logic                    byte_valid;
    logic                    last;
  } grp_t;

endpackage

>>> design/bmc_decode.sv
// Marker matching: held prefix and one byte in, result group and next prefix out.
module bmc_decode
  import bmc_pkg::*;
(
  input  hold_t      held,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  output grp_t       grp,
  output hold_t      held_nxt
);

  always_comb begin
    logic do_fresh;
    grp        = '0;
    grp.byte_valid = 1'b1;
    held_nxt   = HOLD_NONE;
    do_fresh   = 1'b0;

    unique case (held)
      HOLD_NONE: begin
        do_fresh = 1'b1;
      end
      HOLD_C4: begin
        if (in_byte == BYTE_A0) begin
          grp.data[grp.cnt] = BYTE_SPACE;
          grp.cnt = grp.cnt + 2'd1;
        end else if (in_byte == BYTE_8A) begin
          grp.data[grp.cnt] = BYTE_LF;
          grp.cnt = grp.cnt + 2'd1;
        end else if (in_byte >= BYTE_80 && in_byte < BYTE_C0) begin
          held_nxt = HOLD_NONE;
        end else begin
          grp.data[grp.cnt] = BYTE_C4;
          grp.cnt = grp.cnt + 2'd1;
          do_fresh = 1'b1;
        end
      end
      HOLD_E2: begin
        if (in_byte == BYTE_96) begin
          held_nxt = HOLD_E296;
        end else begin
          grp.data[grp.cnt] = BYTE_E2;
          grp.cnt = grp.cnt + 2'd1;
          do_fresh = 1'b1;
        end
      end
      HOLD_E296: begin
        if (in_byte == BYTE_81) begin
          grp.data[grp.cnt] = BYTE_SPACE;
          grp.cnt = grp.cnt + 2'd1;
        end else begin
          grp.data[grp.cnt] = BYTE_E2;
          grp.cnt = grp.cnt + 2'd1;
          grp.data[grp.cnt] = BYTE_96;
          grp.cnt = grp.cnt + 2'd1;
          do_fresh = 1'b1;
        end
      end
    endcase

    if (do_fresh) begin
      if (in_byte == BYTE_C4) begin
        held_nxt = HOLD_C4;
      end else if (in_byte == BYTE_E2) begin
        held_nxt = HOLD_E2;
      end else begin
        held_nxt = HOLD_NONE;
        grp.data[grp.cnt] = in_byte;
        grp.cnt = grp.cnt + 2'd1;
      end
    end

    if (in_end_of_text) begin
      unique case (held_nxt)
        HOLD_NONE: begin
        end
        HOLD_C4: begin
          grp.data[grp.cnt] = BYTE_C4;
          grp.cnt = grp.cnt + 2'd1;
        end
        HOLD_E2: begin
          grp.data[grp.cnt] = BYTE_E2;
          grp.cnt = grp.cnt + 2'd1;
        end
        HOLD_E296: begin
          grp.data[grp.cnt] = BYTE_E2;
          grp.cnt = grp.cnt + 2'd1;
          grp.data[grp.cnt] = BYTE_96;
          grp.cnt = grp.cnt + 2'd1;
        end
      endcase
      held_nxt = HOLD_NONE;
      if (grp.cnt == 2'd0) begin
        // bare end marker
        grp.cnt        = 2'd1;
        grp.data       = '0;
        grp.byte_valid = 1'b0;
      end
      grp.last = 1'b1;
    end
  end

endmodule

>>> design/bmc_outbuf.sv
// Result register: holds one group and hands it out a byte per transfer.
module bmc_outbuf
  import bmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  grp_t       grp,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_last
);

  logic [1:0]              cnt_r;
  logic [1:0]              cnt_nxt;
  logic [GRP_MAX-1:0][7:0] data_r;
  logic [GRP_MAX-1:0][7:0] data_nxt;
  logic                    bv_r;
  logic                    last_r;
  logic                    take;

  assign out_valid      = (cnt_r != 2'd0);
  assign take           = out_valid && out_ready;
  assign can_load       = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign out_byte       = data_r[0];
  assign out_byte_valid = bv_r;
  assign out_last       = last_r && (cnt_r == 2'd1);

  always_comb begin
    cnt_nxt  = cnt_r;
    data_nxt = data_r;
    if (load) begin
      cnt_nxt  = grp.cnt;
      data_nxt = grp.data;
    end else if (take) begin
      cnt_nxt  = cnt_r - 2'd1;
      data_nxt = {8'h00, data_r[GRP_MAX-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    data_r <= data_nxt;
    if (load) begin
      bv_r   <= grp.byte_valid;
      last_r <= grp.last;
    end
  end

endmodule

>>> design/bpe_marker_cleaner.sv
// Top level of the BPE marker cleaner.
// Takes one byte of token text per transfer and emits cleaned bytes: C4 A0 and
// E2 96 81 become a space, C4 8A a newline, other C4 xx (xx in 80..BF) vanish,
// and a prefix that fails to match goes out unchanged. A byte is accepted every
// cycle while each byte yields at most one result and out_ready is high; a byte
// that yields more (at most three) holds the input until the result register
// is down to its last result and out_ready is high, as it hands out one byte
// per transfer. End of text flushes any held prefix and marks the final result
// with out_last, or sends a bare marker with out_byte_valid low if there is none.
module bpe_marker_cleaner
  import bmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_last
);

`include "bpe_marker_cleaner_assert.svh"

  hold_t held_r;
  hold_t held_nxt;
  grp_t  grp;
  logic  in_fire;
  logic  can_load;

  bmc_decode u_decode (
    .held           (held_r),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .grp            (grp),
    .held_nxt       (held_nxt)
  );

  assign in_ready = can_load;
  assign in_fire  = in_valid && in_ready;

  bmc_outbuf u_outbuf (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (in_fire && (grp.cnt != 2'd0)),
    .grp            (grp),
    .can_load       (can_load),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= HOLD_NONE;
    end else if (in_fire) begin
      held_r <= held_nxt;
    end
  end

  `BMC_ASSERT(a_eot_clears, in_fire && in_end_of_text |=> held_r == HOLD_NONE, "prefix held after end of text")
  `BMC_ASSERT(a_bare_marker, out_valid && !out_byte_valid |-> out_last && (out_byte == 8'h00), "bad bare marker")
  `BMC_ASSERT(a_fire_output, in_fire && !in_end_of_text && (held_r == HOLD_NONE) && (in_byte != BYTE_C4) && (in_byte != BYTE_E2) |=> out_valid && (out_byte == $past(in_byte)), "plain byte not passed")
  `BMC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && (held_r == HOLD_NONE), "not idle after reset")

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the BPE marker cleaner: byte stream in, cleaned bytes out.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bmc_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic       eot;
  } txt_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic       last;
  } clean_t;

  typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_BACKLOG} phase_t;

  localparam int HOLD_CYCLES = 80;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_text = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_last;

  txt_item_t byte_q[$];
  clean_t    clean_q[$];
  txt_item_t nxt_item;
  clean_t    got;
  hold_t     held = HOLD_NONE;
  phase_t    phase = PH_FREE;
  int        step_n;
  int        hold_cnt = 0;
  int        errors = 0;

  bpe_marker_cleaner DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

  function automatic int send_idle_pct();
    return (phase == PH_SEND_IDLE) ? 52 : (phase == PH_BOTH) ? 18 : 0;
  endfunction

  function automatic int recv_stall_pct();
    return (phase == PH_RECV_STALL) ? 52 : (phase == PH_BOTH) ? 18 : 0;
  endfunction

  function automatic void put_clean(logic [7:0] v);
    clean_q.push_back('{data: v, vld: 1'b1, last: 1'b0});
    step_n++;
  endfunction

  function automatic void take_fresh(logic [7:0] v);
    if (v == BYTE_C4) held = HOLD_C4;
    else if (v == BYTE_E2) held = HOLD_E2;
    else begin
      held = HOLD_NONE;
      put_clean(v);
    end
  endfunction

  function automatic void predict_clean(logic [7:0] v, logic eot);
    clean_t tail;
    step_n = 0;
    case (held)
      HOLD_C4: begin
        if (v == BYTE_A0) begin
          held = HOLD_NONE;
          put_clean(BYTE_SPACE);
        end else if (v == BYTE_8A) begin
          held = HOLD_NONE;
          put_clean(BYTE_LF);
        end else if (v >= BYTE_80 && v < BYTE_C0) begin
          held = HOLD_NONE;
        end else begin
          put_clean(BYTE_C4);
          take_fresh(v);
        end
      end
      HOLD_E2: begin
        if (v == BYTE_96) held = HOLD_E296;
        else begin
          put_clean(BYTE_E2);
          take_fresh(v);
        end
      end
      HOLD_E296: begin
        if (v == BYTE_81) begin
          held = HOLD_NONE;
          put_clean(BYTE_SPACE);
        end else begin
          put_clean(BYTE_E2);
          put_clean(BYTE_96);
          take_fresh(v);
        end
      end
      default: take_fresh(v);
    endcase
    if (eot) begin
      case (held)
        HOLD_C4: put_clean(BYTE_C4);
        HOLD_E2: put_clean(BYTE_E2);
        HOLD_E296: begin
          put_clean(BYTE_E2);
          put_clean(BYTE_96);
        end
        default: ;
      endcase
      held = HOLD_NONE;
      if (step_n == 0) begin
        clean_q.push_back('{data: 8'h00, vld: 1'b0, last: 1'b1});
      end else begin
        tail = clean_q.pop_back();
        tail.last = 1'b1;
        clean_q.push_back(tail);
      end
    end
  endfunction

  function automatic void push_item(logic [7:0] v, logic eot);
    byte_q.push_back('{b: v, eot: eot});
  endfunction

  function automatic logic coin_eot();
    return ($urandom_range(0, 9) == 0);
  endfunction

  // well-formed marker sequences, broken prefixes and plain random bytes, mixed
  task automatic add_random(int n);
    int target;
    target = byte_q.size() + n;
    while (byte_q.size() < target) begin
      case ($urandom_range(0, 11))
        4: begin
          push_item(BYTE_C4, coin_eot());
          push_item(BYTE_A0, coin_eot());
        end
        5: begin
          push_item(BYTE_C4, coin_eot());
          push_item(BYTE_8A, coin_eot());
        end
        6: begin
          push_item(BYTE_C4, coin_eot());
          push_item(8'($urandom_range(8'h80, 8'hBF)), coin_eot());
        end
        7, 8: begin
          push_item(BYTE_E2, coin_eot());
          push_item(BYTE_96, coin_eot());
          push_item(BYTE_81, coin_eot());
        end
        9: begin
          push_item(BYTE_C4, coin_eot());
          push_item(8'($urandom_range(0, 255)), coin_eot());
        end
        10: begin
          push_item(BYTE_E2, coin_eot());
          push_item(8'($urandom_range(0, 255)), coin_eot());
        end
        11: begin
          push_item(BYTE_E2, coin_eot());
          push_item(BYTE_96, coin_eot());
          push_item(8'($urandom_range(0, 255)), coin_eot());
        end
        default: push_item(8'($urandom_range(0, 255)), coin_eot());
      endcase
    end
  endtask

  task automatic drain();
    while (byte_q.size() != 0 || in_valid || clean_q.size() != 0) @(negedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
        nxt_item = byte_q.pop_front();
        in_valid <= 1'b1;
        in_byte <= nxt_item.b;
        in_end_of_text <= nxt_item.eot;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off at the start of the backlog phase
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (phase == PH_BACKLOG && hold_cnt < HOLD_CYCLES) begin
      hold_cnt <= hold_cnt + 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct());
    end
  end

  // predict on each input transfer, then check each output transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) predict_clean(in_byte, in_end_of_text);
      if (out_valid && out_ready) begin
        if (clean_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: byte %02h valid %0b last %0b", $time,
                   out_byte, out_byte_valid, out_last);
        end else begin
          got = clean_q.pop_front();
          if (out_byte !== got.data || out_byte_valid !== got.vld ||
              out_last !== got.last) begin
            errors++;
            $display("%0t: mismatch: expected byte %02h valid %0b last %0b,",
                     $time, got.data, got.vld, got.last,
                     " actual byte %02h valid %0b last %0b",
                     out_byte, out_byte_valid, out_last);
          end
        end
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    phase = PH_FREE;
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(BYTE_C4, 1'b0); push_item(BYTE_A0, 1'b0);
    push_item(BYTE_C4, 1'b0); push_item(BYTE_8A, 1'b0);
    push_item(BYTE_C4, 1'b0); push_item(BYTE_80, 1'b0);
    // dropped pair closing the text: bare end marker
    push_item(BYTE_C4, 1'b0); push_item(8'hBF, 1'b1);
    push_item(BYTE_C4, 1'b0); push_item(8'h7F, 1'b0);
    push_item(BYTE_C4, 1'b0); push_item(BYTE_C0, 1'b0);
    push_item(BYTE_E2, 1'b0); push_item(BYTE_96, 1'b0); push_item(BYTE_81, 1'b0);
    push_item(BYTE_E2, 1'b0); push_item(BYTE_96, 1'b0); push_item(BYTE_C4, 1'b0);
    push_item(BYTE_8A, 1'b0);
    push_item(BYTE_E2, 1'b0); push_item(BYTE_E2, 1'b1);
    push_item(BYTE_E2, 1'b0); push_item(BYTE_96, 1'b1);
    push_item(BYTE_C4, 1'b1);
    add_random(56);
    drain();

    phase = PH_SEND_IDLE;
    add_random(75);
    drain();

    phase = PH_RECV_STALL;
    add_random(75);
    drain();

    phase = PH_BOTH;
    add_random(75);
    drain();

    phase = PH_BACKLOG;
    add_random(75);
    drain();

    repeat (10) @(negedge clk);
    if (clean_q.size() != 0) begin
      errors += clean_q.size();
      $display("%0t: %0d expected results never arrived", $time, clean_q.size());
    end
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
